[rtl/pcx_pkg.sv]
// ----------------------------------------------------------------------------
// pcx_pkg
// Shared widths, codes and item types of the PCX run-length palette decoder.
// ----------------------------------------------------------------------------
package pcx_pkg;

  localparam int unsigned IMG_W      = 23;  // pixel count / limit width
  localparam int unsigned POS_W      = 22;  // raster position width
  localparam int unsigned CNT_W      = 6;   // run length width
  localparam int unsigned IDX_W      = 8;   // palette index width
  localparam int unsigned COL_W      = 8;   // one color component
  localparam int unsigned RGB_W      = 3 * COL_W;
  localparam int unsigned PAL_DEPTH  = 256;

  localparam logic [IMG_W-1:0] MAX_PIXELS = 23'd4194304;
  localparam logic [7:0]       RUN_MARK   = 8'hbf;  // bytes above this open a run
  localparam logic [7:0]       RUN_MASK   = 8'h3f;

  // queue depths, powers of two so the pointers wrap on their own
  localparam int unsigned OPQ_DEPTH = 4;
  localparam int unsigned OPQ_AW    = $clog2(OPQ_DEPTH);
  localparam int unsigned OPQ_CW    = $clog2(OPQ_DEPTH + 1);
  localparam int unsigned OUTQ_DEPTH = 4;
  localparam int unsigned OUTQ_AW    = $clog2(OUTQ_DEPTH);
  localparam int unsigned OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

  typedef enum logic {
    REQ_PAL  = 1'b0,
    REQ_DATA = 1'b1
  } req_e;

  typedef enum logic {
    OP_PAL = 1'b0,
    OP_PIX = 1'b1
  } op_kind_e;

  // one operation handed from front to back
  typedef struct packed {
    op_kind_e         kind;
    logic [IDX_W-1:0] idx;
    logic [RGB_W-1:0] rgb;
    logic [CNT_W-1:0] cnt;   // pixels to emit, never zero for OP_PIX
    logic             done;  // job ends the image
  } op_t;

  typedef struct packed {
    logic [COL_W-1:0] red;
    logic [COL_W-1:0] green;
    logic [COL_W-1:0] blue;
    logic [POS_W-1:0] pos;
    logic             last;
    logic             done;
  } pix_t;

endpackage

[rtl/pcx_rle_palette_decoder.sv]
// ----------------------------------------------------------------------------
// pcx_rle_palette_decoder
// Run-length PCX pixel decoder with a 256-entry RGB palette.
// ----------------------------------------------------------------------------
//  channel   handshake           payload
//  input     push / full         req_type, pal_index, pal_red/green/blue,
//                                data_byte
//  result    empty / pop         red, green, blue, pixel_position,
//                                last_of_run, image_done
//  config    cfg_valid / ready   cfg_data = image_pixels
//
//  Each input item is accepted with a single push; a run index byte leaves
//  a job of n pixels that the back end emits at one pixel per cycle while
//  the output buffer has room, bound by the single palette RAM read port.
//  A pixel passes the operation queue, the job registers, the palette RAM
//  read and the output buffer. The input stalls when the operation queue
//  fills and in the cycle after a configuration write.
//  Reset clears control state only; palette contents are undefined.
// ----------------------------------------------------------------------------
module pcx_rle_palette_decoder import pcx_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  logic             req_type_i,
  input  logic [IDX_W-1:0] pal_index_i,
  input  logic [COL_W-1:0] pal_red_i,
  input  logic [COL_W-1:0] pal_green_i,
  input  logic [COL_W-1:0] pal_blue_i,
  input  logic [7:0]       data_byte_i,
  output logic             empty,
  input  logic             pop,
  output logic [COL_W-1:0] red_o,
  output logic [COL_W-1:0] green_o,
  output logic [COL_W-1:0] blue_o,
  output logic [POS_W-1:0] pixel_position_o,
  output logic             last_of_run_o,
  output logic             image_done_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [IMG_W-1:0] cfg_data_i
);

  logic opq_push, opq_full, opq_pop, opq_empty;
  op_t  op_in, op_out;
  pix_t pix;

  pcx_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .req_type_i  (req_type_i),
    .pal_index_i (pal_index_i),
    .pal_red_i   (pal_red_i),
    .pal_green_i (pal_green_i),
    .pal_blue_i  (pal_blue_i),
    .data_byte_i (data_byte_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .opq_full_i  (opq_full),
    .opq_push_o  (opq_push),
    .opq_op_o    (op_in)
  );

  pcx_opq u_opq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (opq_push),
    .op_i    (op_in),
    .full_o  (opq_full),
    .pop_i   (opq_pop),
    .op_o    (op_out),
    .empty_o (opq_empty)
  );

  pcx_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .opq_empty_i (opq_empty),
    .opq_op_i    (op_out),
    .opq_pop_o   (opq_pop),
    .empty       (empty),
    .pop         (pop),
    .pix_o       (pix)
  );

  assign red_o            = pix.red;
  assign green_o          = pix.green;
  assign blue_o           = pix.blue;
  assign pixel_position_o = pix.pos;
  assign last_of_run_o    = pix.last;
  assign image_done_o     = pix.done;

endmodule

[rtl/pcx_ram.sv]
// ----------------------------------------------------------------------------
// pcx_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pcx_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // a read and a write to the same entry in one cycle return the old data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/pcx_front.sv]
// ----------------------------------------------------------------------------
// pcx_front
// Accepts input items, tracks run headers and the pixel budget; palette items
// become palette writes, pixel bytes in budget pixel jobs for the back end.
// ----------------------------------------------------------------------------
module pcx_front import pcx_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  logic             req_type_i,
  input  logic [IDX_W-1:0] pal_index_i,
  input  logic [COL_W-1:0] pal_red_i,
  input  logic [COL_W-1:0] pal_green_i,
  input  logic [COL_W-1:0] pal_blue_i,
  input  logic [7:0]       data_byte_i,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [IMG_W-1:0] cfg_data_i,
  input  logic             opq_full_i,
  output logic             opq_push_o,
  output op_t              opq_op_o
);

  logic [IMG_W-1:0] lim_q, lim_d;
  logic [IMG_W-1:0] sched_q, sched_d;
  logic [IMG_W-1:0] remaining_q, remaining_d;
  logic             recalc_q, recalc_d;
  logic             pend_q, pend_d;
  logic [CNT_W-1:0] rcnt_q, rcnt_d;
  logic [CNT_W-1:0] n_run;
  logic [CNT_W-1:0] job_n;
  logic             accept;

  assign cfg_ready_o = 1'b1;
  assign full        = opq_full_i | recalc_q;
  assign accept      = push & ~full;

  // cut a pending run at the pixels still left in the image
  assign n_run = (remaining_q < IMG_W'(rcnt_q)) ? remaining_q[CNT_W-1:0] : rcnt_q;

  always_comb begin
    lim_d       = lim_q;
    sched_d     = sched_q;
    remaining_d = remaining_q;
    recalc_d    = 1'b0;
    pend_d      = pend_q;
    rcnt_d      = rcnt_q;
    job_n       = '0;
    opq_push_o  = 1'b0;
    opq_op_o    = '0;

    if (recalc_q) begin
      remaining_d = (lim_q > sched_q) ? (lim_q - sched_q) : '0;
    end

    if (accept) begin
      if (req_type_i == REQ_PAL) begin
        opq_push_o    = 1'b1;
        opq_op_o.kind = OP_PAL;
        opq_op_o.idx  = pal_index_i;
        opq_op_o.rgb  = {pal_red_i, pal_green_i, pal_blue_i};
      end else if (remaining_q != '0) begin
        if (pend_q) begin
          pend_d = 1'b0;
          rcnt_d = '0;
          job_n  = n_run;
        end else if (data_byte_i > RUN_MARK) begin
          pend_d = 1'b1;
          rcnt_d = CNT_W'(data_byte_i & RUN_MASK);
        end else begin
          job_n = CNT_W'(1);
        end
        if (job_n != '0) begin
          opq_push_o    = 1'b1;
          opq_op_o.kind = OP_PIX;
          opq_op_o.idx  = data_byte_i;
          opq_op_o.cnt  = job_n;
          opq_op_o.done = (remaining_q == IMG_W'(job_n));
          remaining_d   = remaining_q - IMG_W'(job_n);
          sched_d       = sched_q + IMG_W'(job_n);
        end
      end
    end

    // new limit; budget is worked out again in the next cycle
    if (cfg_valid_i) begin
      lim_d    = (cfg_data_i > MAX_PIXELS) ? MAX_PIXELS : cfg_data_i;
      recalc_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q       <= '0;
      sched_q     <= '0;
      remaining_q <= '0;
      recalc_q    <= 1'b0;
      pend_q      <= 1'b0;
      rcnt_q      <= '0;
    end else begin
      lim_q       <= lim_d;
      sched_q     <= sched_d;
      remaining_q <= remaining_d;
      recalc_q    <= recalc_d;
      pend_q      <= pend_d;
      rcnt_q      <= rcnt_d;
    end
  end

endmodule

[rtl/pcx_opq.sv]
// ----------------------------------------------------------------------------
// pcx_opq
// Short operation queue between the front and the back end.
// ----------------------------------------------------------------------------
module pcx_opq import pcx_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  op_i,
  output logic full_o,
  input  logic pop_i,
  output op_t  op_o,
  output logic empty_o
);

  op_t               buf_q [OPQ_DEPTH];
  logic [OPQ_AW-1:0] wr_q, rd_q;
  logic [OPQ_CW-1:0] cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == OPQ_CW'(OPQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign op_o    = buf_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + OPQ_AW'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + OPQ_AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + OPQ_CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - OPQ_CW'(1);
      end
    end
  end

endmodule

[rtl/pcx_back.sv]
// ----------------------------------------------------------------------------
// pcx_back
// Carries out queued operations: writes palette entries and expands pixel jobs
// via the palette RAM into a buffer, one pixel a cycle while it has room.
// ----------------------------------------------------------------------------
module pcx_back import pcx_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic opq_empty_i,
  input  op_t  opq_op_i,
  output logic opq_pop_o,
  output logic empty,
  input  logic pop,
  output pix_t pix_o
);

  logic             busy_q;
  logic [IDX_W-1:0] idx_q;
  logic [CNT_W-1:0] cnt_q;
  logic             done_q;
  logic [POS_W-1:0] pos_q;

  logic             v1_q;
  logic [POS_W-1:0] pos1_q;
  logic             last1_q, done1_q;
  logic [RGB_W-1:0] rgb1;

  pix_t               oq_q [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0] oq_wr_q, oq_rd_q;
  logic [OUTQ_CW-1:0] oq_cnt_q;
  logic               oq_pop;

  logic can_issue, issue, final_px, take, pal_we;

  // leave room in the output buffer for the pixel still in the RAM read
  assign can_issue = (oq_cnt_q + OUTQ_CW'(v1_q)) < OUTQ_CW'(OUTQ_DEPTH);
  assign issue     = busy_q & can_issue;
  assign final_px  = (cnt_q == CNT_W'(1));
  assign take      = ~opq_empty_i & (~busy_q | (issue & final_px));
  assign opq_pop_o = take;
  assign pal_we    = take & (opq_op_i.kind == OP_PAL);

  pcx_ram #(
    .Width (RGB_W),
    .Depth (PAL_DEPTH)
  ) u_pal (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (opq_op_i.idx),
    .wdata_i (opq_op_i.rgb),
    .raddr_i (idx_q),
    .rdata_o (rgb1)
  );

  always_ff @(posedge clk_i) begin
    if (take && opq_op_i.kind == OP_PIX) begin
      idx_q  <= opq_op_i.idx;
      done_q <= opq_op_i.done;
    end
    if (issue) begin
      pos1_q  <= pos_q;
      last1_q <= final_px;
      done1_q <= done_q & final_px;
    end
    if (v1_q) begin
      oq_q[oq_wr_q] <= '{red:   rgb1[RGB_W-1 -: COL_W],
                         green: rgb1[2*COL_W-1 -: COL_W],
                         blue:  rgb1[COL_W-1:0],
                         pos:   pos1_q,
                         last:  last1_q,
                         done:  done1_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      pos_q  <= '0;
      v1_q   <= 1'b0;
    end else begin
      v1_q <= issue;
      if (issue) begin
        pos_q <= pos_q + POS_W'(1);
        cnt_q <= cnt_q - CNT_W'(1);
        if (final_px) begin
          busy_q <= 1'b0;
        end
      end
      // load the next job; a palette write is done as it is taken
      if (take && opq_op_i.kind == OP_PIX) begin
        busy_q <= 1'b1;
        cnt_q  <= opq_op_i.cnt;
      end
    end
  end

  assign empty  = (oq_cnt_q == '0);
  assign oq_pop = pop & ~empty;
  assign pix_o  = oq_q[oq_rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= '0;
      oq_rd_q  <= '0;
      oq_cnt_q <= '0;
    end else begin
      if (v1_q) begin
        oq_wr_q <= oq_wr_q + OUTQ_AW'(1);
      end
      if (oq_pop) begin
        oq_rd_q <= oq_rd_q + OUTQ_AW'(1);
      end
      if (v1_q && !oq_pop) begin
        oq_cnt_q <= oq_cnt_q + OUTQ_CW'(1);
      end else if (oq_pop && !v1_q) begin
        oq_cnt_q <= oq_cnt_q - OUTQ_CW'(1);
      end
    end
  end

endmodule

[verif/pcx_rle_palette_decoder_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcx_rle_palette_decoder_test
// Self-checking bench for the PCX run-length palette decoder. A short
// table of directed items covers the corner cases of the run coding, then
// random palette writes, literals and runs are fed with random gaps on both
// sides. Each pixel is checked against a local decoder model or a typed value.
// ----------------------------------------------------------------------------
module pcx_rle_palette_decoder_test;
  import pcx_pkg::*;

  localparam int unsigned RAND_ITEMS   = 320;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned CYCLE_LIMIT  = 1000000;

  typedef enum logic [1:0] {
    EXP_MODEL,  // expected pixels come from the decoder model
    EXP_ONE,    // one pixel typed into the table
    EXP_NONE    // no pixel at all
  } exp_e;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_e;

  typedef struct packed {
    req_e             kind;
    logic [IDX_W-1:0] pal_idx;
    logic [COL_W-1:0] red;
    logic [COL_W-1:0] green;
    logic [COL_W-1:0] blue;
    logic [7:0]       data;
  } item_t;

  typedef struct {
    row_e             op;
    item_t            it;
    logic [IMG_W-1:0] cfg;
    exp_e             chk;
    pix_t             px;
  } dir_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             push;
  logic             full;
  logic             req_type_i;
  logic [IDX_W-1:0] pal_index_i;
  logic [COL_W-1:0] pal_red_i;
  logic [COL_W-1:0] pal_green_i;
  logic [COL_W-1:0] pal_blue_i;
  logic [7:0]       data_byte_i;
  logic             empty;
  logic             pop;
  logic [COL_W-1:0] red_o;
  logic [COL_W-1:0] green_o;
  logic [COL_W-1:0] blue_o;
  logic [POS_W-1:0] pixel_position_o;
  logic             last_of_run_o;
  logic             image_done_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [IMG_W-1:0] cfg_data_i;

  // decoder model state
  logic [RGB_W-1:0] pal_mem [PAL_DEPTH];
  bit               pal_known [PAL_DEPTH];
  bit               run_open;
  logic [CNT_W-1:0] run_len;
  logic [IMG_W-1:0] emitted;
  logic [IMG_W-1:0] img_pixels;

  pix_t     decoded_q[$];
  pix_t     pixel_expect_q[$];
  dir_row_t dir_tab[$];

  int unsigned errors;
  int unsigned cycles;
  int unsigned items_fed;
  int unsigned rx_wait;
  int unsigned rx_hold;
  bit          steady;
  pix_t        got_px;
  pix_t        want_px;

  pcx_rle_palette_decoder u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .req_type_i       (req_type_i),
    .pal_index_i      (pal_index_i),
    .pal_red_i        (pal_red_i),
    .pal_green_i      (pal_green_i),
    .pal_blue_i       (pal_blue_i),
    .data_byte_i      (data_byte_i),
    .empty            (empty),
    .pop              (pop),
    .red_o            (red_o),
    .green_o          (green_o),
    .blue_o           (blue_o),
    .pixel_position_o (pixel_position_o),
    .last_of_run_o    (last_of_run_o),
    .image_done_o     (image_done_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // decoder model
  // ---------------------------------------------------------------------------
  function automatic logic [IMG_W-1:0] pixel_cap();
    return (img_pixels > MAX_PIXELS) ? MAX_PIXELS : img_pixels;
  endfunction

  function automatic void emit_run(logic [7:0] idx, int unsigned n);
    pix_t        p;
    int unsigned i;
    for (i = 0; i < n && emitted < pixel_cap(); i++) begin
      {p.red, p.green, p.blue} = pal_mem[idx];
      p.pos  = emitted[POS_W-1:0];
      emitted = emitted + 1'b1;
      p.done = (emitted >= pixel_cap());
      // the run ends here, either by its count or by the image limit
      p.last = (i + 1 == n) || p.done;
      decoded_q.push_back(p);
    end
  endfunction

  function automatic void decode_item(item_t it);
    int unsigned n;
    decoded_q.delete();
    if (it.kind == REQ_PAL) begin
      pal_mem[it.pal_idx]   = {it.red, it.green, it.blue};
      pal_known[it.pal_idx] = 1'b1;
    end else if (emitted < pixel_cap()) begin
      if (run_open) begin
        n        = run_len;
        run_open = 1'b0;
        run_len  = '0;
        emit_run(it.data, n);
      end else if (it.data > RUN_MARK) begin
        run_open = 1'b1;
        run_len  = CNT_W'(it.data & RUN_MASK);
      end else begin
        emit_run(it.data, 1);
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------
  task automatic flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
    $display("%0t: %s expected %0h got %0h", $time, what, want, got);
    errors++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && pop === 1'b1 && empty === 1'b0) begin
      got_px = '{red: red_o, green: green_o, blue: blue_o, pos: pixel_position_o,
                 last: last_of_run_o, done: image_done_o};
      if (pixel_expect_q.size() == 0) begin
        $display("%0t: pixel at %0h with none expected", $time, pixel_position_o);
        errors++;
      end else begin
        want_px = pixel_expect_q.pop_front();
        if (got_px.red !== want_px.red) flag_mismatch("red", want_px.red, got_px.red);
        if (got_px.green !== want_px.green)
          flag_mismatch("green", want_px.green, got_px.green);
        if (got_px.blue !== want_px.blue) flag_mismatch("blue", want_px.blue, got_px.blue);
        if (got_px.pos !== want_px.pos)
          flag_mismatch("pixel_position", want_px.pos, got_px.pos);
        if (got_px.last !== want_px.last)
          flag_mismatch("last_of_run", want_px.last, got_px.last);
        if (got_px.done !== want_px.done)
          flag_mismatch("image_done", want_px.done, got_px.done);
      end
      rx_wait = steady ? 0 : $urandom_range(0, 10);
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold--;
      pop <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------
  function automatic item_t rand_item(req_e k);
    item_t it;
    it.kind    = k;
    it.pal_idx = 8'($urandom_range(0, 255));
    it.red     = 8'($urandom_range(0, 255));
    it.green   = 8'($urandom_range(0, 255));
    it.blue    = 8'($urandom_range(0, 255));
    it.data    = 8'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic pix_t px(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                              int unsigned pos, logic last, logic done);
    pix_t p;
    p = '{red: r, green: g, blue: b, pos: POS_W'(pos), last: last, done: done};
    return p;
  endfunction

  task automatic push_item(item_t it, exp_e chk, pix_t typed);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 10);
    @(negedge clk_i);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push        <= 1'b1;
    req_type_i  <= it.kind;
    pal_index_i <= it.pal_idx;
    pal_red_i   <= it.red;
    pal_green_i <= it.green;
    pal_blue_i  <= it.blue;
    data_byte_i <= it.data;
    do @(posedge clk_i); while (full);
    items_fed++;
    decode_item(it);
    case (chk)
      EXP_MODEL: foreach (decoded_q[i]) pixel_expect_q.push_back(decoded_q[i]);
      EXP_ONE:   pixel_expect_q.push_back(typed);
      default:   ;
    endcase
  endtask

  // write the palette entry first if this byte is about to be looked up and has no entry yet
  task automatic send_data(logic [7:0] b);
    item_t it;
    item_t pw;
    it      = rand_item(REQ_DATA);
    it.data = b;
    if (emitted < pixel_cap() && (run_open || b <= RUN_MARK) && !pal_known[b]) begin
      pw         = rand_item(REQ_PAL);
      pw.pal_idx = b;
      push_item(pw, EXP_MODEL, '0);
    end
    push_item(it, EXP_MODEL, '0);
  endtask

  task automatic set_limit(logic [IMG_W-1:0] v);
    @(negedge clk_i);
    push <= 1'b0;
    while (pixel_expect_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    img_pixels = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // directed table
  // ---------------------------------------------------------------------------
  function automatic void add_cfg(logic [IMG_W-1:0] v);
    dir_row_t r;
    r.op  = ROW_CFG;
    r.it  = '0;
    r.cfg = v;
    r.chk = EXP_NONE;
    r.px  = '0;
    dir_tab.push_back(r);
  endfunction

  function automatic void add_pal(logic [7:0] idx, logic [7:0] rd, logic [7:0] gr,
                                  logic [7:0] bl);
    dir_row_t r;
    r.op  = ROW_ITEM;
    r.it  = '{kind: REQ_PAL, pal_idx: idx, red: rd, green: gr, blue: bl, data: 8'h00};
    r.cfg = '0;
    r.chk = EXP_NONE;
    r.px  = '0;
    dir_tab.push_back(r);
  endfunction

  function automatic void add_data(logic [7:0] b, exp_e chk, pix_t p);
    dir_row_t r;
    r.op  = ROW_ITEM;
    r.it  = '{kind: REQ_DATA, pal_idx: 8'h00, red: 8'h00, green: 8'h00, blue: 8'h00,
              data: b};
    r.cfg = '0;
    r.chk = chk;
    r.px  = p;
    dir_tab.push_back(r);
  endfunction

  initial begin
    add_cfg(0);
    add_data(8'h07, EXP_NONE, '0);                  // zero limit, ignored
    add_pal(8'h00, 8'h00, 8'h00, 8'h00);
    add_pal(8'hff, 8'hff, 8'hff, 8'hff);
    add_pal(8'hbf, 8'h12, 8'h34, 8'h56);
    add_pal(8'h2a, 8'ha5, 8'h5a, 8'hc3);
    add_cfg(20);
    add_data(8'h00, EXP_ONE, px(8'h00, 8'h00, 8'h00, 0, 1'b1, 1'b0));
    add_data(8'hbf, EXP_ONE, px(8'h12, 8'h34, 8'h56, 1, 1'b1, 1'b0));
    add_data(8'hc0, EXP_NONE, '0);                  // zero-length run
    add_pal(8'h80, 8'h01, 8'h02, 8'h03);            // write while run pending
    add_data(8'hff, EXP_NONE, '0);
    add_data(8'hc3, EXP_NONE, '0);
    add_pal(8'h80, 8'h07, 8'h08, 8'h09);
    add_data(8'h80, EXP_MODEL, '0);
    add_data(8'hc1, EXP_NONE, '0);
    add_data(8'h2a, EXP_ONE, px(8'ha5, 8'h5a, 8'hc3, 5, 1'b1, 1'b0));
    add_data(8'hff, EXP_NONE, '0);                  // 63-pixel run, cut at the limit
    add_data(8'hff, EXP_MODEL, '0);
    add_data(8'h00, EXP_NONE, '0);                  // image complete
    add_data(8'hc5, EXP_NONE, '0);
    add_cfg(10);
    add_data(8'h00, EXP_NONE, '0);                  // limit below the count
    add_cfg(21);
    add_data(8'h2a, EXP_ONE, px(8'ha5, 8'h5a, 8'hc3, 20, 1'b1, 1'b1));
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned      ph;
    int unsigned      n;
    int unsigned      r;
    logic [7:0]       hdr;
    logic [IMG_W-1:0] v;

    rst_ni      = 1'b0;
    push        = 1'b0;
    pop         = 1'b0;
    req_type_i  = REQ_PAL;
    pal_index_i = '0;
    pal_red_i   = '0;
    pal_green_i = '0;
    pal_blue_i  = '0;
    data_byte_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    errors      = 0;
    cycles      = 0;
    rx_wait     = 0;
    rx_hold     = 0;
    steady      = 1'b0;
    run_open    = 1'b0;
    run_len     = '0;
    emitted     = '0;
    img_pixels  = '0;
    foreach (pal_known[i]) begin
      pal_known[i] = 1'b0;
      pal_mem[i]   = '0;
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].op == ROW_CFG) set_limit(dir_tab[i].cfg);
      else push_item(dir_tab[i].it, dir_tab[i].chk, dir_tab[i].px);
    end

    items_fed = 0;
    ph = 0;
    while (items_fed < RAND_ITEMS) begin
      n = $urandom_range(20, 50);
      case ($urandom_range(0, 7))
        0:       v = {IMG_W{1'b1}};
        1:       v = MAX_PIXELS;
        2: begin
          v = emitted;
          n = 6;
        end
        3: begin
          v = IMG_W'($urandom_range(0, emitted));
          n = 6;
        end
        default: v = emitted + IMG_W'($urandom_range(30, 400));
      endcase
      if (ph == 0) v = {IMG_W{1'b1}};
      set_limit(v);
      steady = ($urandom_range(0, 3) == 0);
      // stall the pixel side for a while so the block backs up
      if (ph == 0) rx_hold = HOLD_CYCLES;
      ph++;
      repeat (n) begin
        r = $urandom_range(0, 99);
        if (r < 15) begin
          push_item(rand_item(REQ_PAL), EXP_MODEL, '0);
        end else if (r < 22) begin
          send_data(8'($urandom_range(0, 255)));
        end else if (r < 50) begin
          send_data(8'($urandom_range(0, RUN_MARK)));
        end else begin
          if (r < 58) hdr = 8'hc0;
          else if (r < 80) hdr = 8'hc0 | 8'($urandom_range(1, 8));
          else hdr = 8'hc0 | 8'($urandom_range(1, 63));
          send_data(hdr);
          if ($urandom_range(0, 4) == 0) push_item(rand_item(REQ_PAL), EXP_MODEL, '0);
          send_data(8'($urandom_range(0, 255)));
        end
      end
    end

    @(negedge clk_i);
    push <= 1'b0;
    while (pixel_expect_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[pcx_rle_palette_decoder.f]
rtl/pcx_pkg.sv
rtl/pcx_ram.sv
rtl/pcx_front.sv
rtl/pcx_opq.sv
rtl/pcx_back.sv
rtl/pcx_rle_palette_decoder.sv
verif/pcx_rle_palette_decoder_test.sv
